// ===== rtl/core/tfct_pkg.sv =====
// Shared types and constants for the term frequency count table.
package tfct_pkg;

    localparam int ENTRIES_DEFAULT = 1024;
    localparam int CAP_W           = 11;
    localparam int KEY_W           = 32;
    localparam int CNT_IN_W        = 16;
    localparam int CTR_W           = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_UPDATED   = 3'd0,
        STAT_INSERTED  = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_DROPPED   = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    // Operation selector
    typedef enum logic {
        FUNC_ADD    = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK
    } state_t;

    // One table slot as stored in the RAM
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CTR_W-1:0] docs;
        logic [CTR_W-1:0] terms;
    } entry_t;

    // One result word
    typedef struct packed {
        status_t          status;
        logic [CTR_W-1:0] docs;
        logic [CTR_W-1:0] terms;
    } result_t;

endpackage

// ===== rtl/core/tfct_mem.sv =====
// Simple dual-port table RAM with registered read data.
module tfct_mem
    import tfct_pkg::*;
#(
    parameter int DEPTH  = ENTRIES_DEFAULT,
    parameter int ADDR_W = $clog2(ENTRIES_DEFAULT)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered on rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tfct_ctrl.sv =====
// Probe sequencer: hashes the key, walks the probe chain and updates the table.
module tfct_ctrl
    import tfct_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    parameter int IDX_W   = $clog2(ENTRIES_DEFAULT),
    parameter int USED_W  = $clog2(ENTRIES_DEFAULT + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    // item in
    input  logic              in_valid,
    output logic              in_ready,
    input  func_t             in_func,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [CNT_IN_W-1:0] in_count,
    input  logic [CAP_W-1:0]  cap,
    // result out
    input  logic              out_free,
    output logic              res_valid,
    output result_t           res,
    // table RAM
    output logic              mem_wr_en,
    output logic [IDX_W-1:0]  mem_wr_addr,
    output entry_t            mem_wr_data,
    output logic              mem_rd_en,
    output logic [IDX_W-1:0]  mem_rd_addr,
    input  entry_t            mem_rd_data
);

    localparam int LIM_W = (USED_W > CAP_W) ? USED_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]    clr_idx_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    probe_reg;
    logic [USED_W-1:0]   used_reg;
    func_t               func_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [CNT_IN_W-1:0] count_reg;

    logic [IDX_W-1:0] home;
    logic [IDX_W-1:0] fold;
    logic [IDX_W:0]   fold_ext;
    logic [IDX_W-1:0] idx_step;

    logic            empty_lookup;
    logic            hit;
    logic            slot_free;
    logic            chain_end;
    logic            done;
    logic            can_insert;
    logic            do_update;
    logic            do_insert;
    logic [CTR_W:0]  docs_sum;
    logic [CTR_W:0]  terms_sum;
    logic [CTR_W-1:0] docs_sat;
    logic [CTR_W-1:0] terms_sat;
    logic            commit;

    // XOR-fold the 32-bit key down to the index width
    function automatic logic [IDX_W-1:0] fold_key(input logic [KEY_W-1:0] k);
        logic [IDX_W-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_W; i++)
        begin
            h[i % IDX_W] = h[i % IDX_W] ^ k[i];
        end
        return h;
    endfunction

    // Home slot, folded value brought below ENTRIES
    always_comb
    begin
        fold     = fold_key(in_key);
        fold_ext = {1'b0, fold};
        if (fold_ext >= (IDX_W+1)'(ENTRIES))
        begin
            home = IDX_W'(fold_ext - (IDX_W+1)'(ENTRIES));
        end
        else
        begin
            home = fold;
        end
    end

    // Linear probe step with wrap
    assign idx_step = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // Slot check and counter update
    always_comb
    begin
        empty_lookup = (func_reg == FUNC_LOOKUP) && (used_reg == '0);
        hit          = mem_rd_data.valid && (mem_rd_data.key == key_reg);
        slot_free    = !mem_rd_data.valid;
        chain_end    = (probe_reg == LAST_IDX);
        done         = empty_lookup || hit || slot_free || chain_end;
        can_insert   = (LIM_W'(used_reg) < LIM_W'(cap)) &&
                       (LIM_W'(used_reg) < LIM_W'(ENTRIES));

        docs_sum  = {1'b0, mem_rd_data.docs} + (CTR_W+1)'(1);
        terms_sum = {1'b0, mem_rd_data.terms} + (CTR_W+1)'(count_reg);
        docs_sat  = docs_sum[CTR_W]  ? '1 : docs_sum[CTR_W-1:0];
        terms_sat = terms_sum[CTR_W] ? '1 : terms_sum[CTR_W-1:0];

        do_update = !empty_lookup && hit && (func_reg == FUNC_ADD);
        do_insert = !empty_lookup && !hit && slot_free &&
                    (func_reg == FUNC_ADD) && can_insert;

        res.status = STAT_DROPPED;
        res.docs   = '0;
        res.terms  = '0;
        if (empty_lookup)
        begin
            res.status = STAT_EMPTY;
        end
        else if (hit)
        begin
            res.status = STAT_UPDATED;
            if (func_reg == FUNC_ADD)
            begin
                res.docs  = docs_sat;
                res.terms = terms_sat;
            end
            else
            begin
                res.docs  = mem_rd_data.docs;
                res.terms = mem_rd_data.terms;
            end
        end
        else if (func_reg == FUNC_LOOKUP)
        begin
            res.status = STAT_NOT_FOUND;
        end
        else if (do_insert)
        begin
            res.status = STAT_INSERTED;
            res.docs   = CTR_W'(1);
            res.terms  = CTR_W'(count_reg);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!done)
                begin
                    state_next = S_READ;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Outputs and RAM control
    always_comb
    begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = '{valid: 1'b1, key: key_reg, docs: res.docs, terms: res.terms};
        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_idx_reg;
                mem_wr_data = '0;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_READ:
            begin
                mem_rd_en = 1'b1;
            end
            S_CHECK:
            begin
                res_valid = done;
                mem_wr_en = done && out_free && (do_update || do_insert);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign commit = res_valid && out_free;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            used_reg    <= '0;
            probe_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (in_valid && in_ready)
            begin
                probe_reg <= '0;
            end
            else if (state_reg == S_CHECK && !done)
            begin
                probe_reg <= probe_reg + 1'b1;
            end
            if (commit && do_insert)
            begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

    // Item registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= in_func;
            key_reg   <= in_key;
            count_reg <= in_count;
            idx_reg   <= home;
        end
        else if (state_reg == S_CHECK && !done)
        begin
            idx_reg <= idx_step;
        end
    end

    // Fill count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LIM_W'(used_reg) <= LIM_W'(ENTRIES))
        else $error("used count above table size");

    // Only an insert moves the fill count
    a_used_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(commit && do_insert) |=> $stable(used_reg))
        else $error("fill count moved without insert");

    // A table write in the check state always goes with a delivered result
    a_write_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && state_reg == S_CHECK) |-> commit)
        else $error("table written without result");

    // An accepted word always starts a read
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_READ))
        else $error("accepted word did not start a probe");

endmodule

// ===== rtl/core/term_frequency_count_table_unit.sv =====
// Top level of the term frequency count table: ports, capacity register, result register.
// Each word is registered, then its linear-probe chain is read and checked slot by slot,
//   starting at the home slot; each probe costs a RAM read and a check.
// No new word is accepted until the result of the last one has gone to the output register.
// Reset: the fill count clears and the capacity returns to CAP_RESET at once, then a sweep
//   clears the slot valid flags in the table RAM with s_axis_tready held low.
module term_frequency_count_table_unit
    import tfct_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key_hash[31:0], add_count[47:32]
    input  logic        s_axis_tuser,   // func
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // doc_count[31:0], term_count[63:32]
    output logic [2:0]  m_axis_tuser,   // status
    // configuration
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data     // capacity_limit
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int USED_W = $clog2(ENTRIES + 1);

    logic [CAP_W-1:0] cap_reg;
    logic             out_valid_reg;
    result_t          out_data_reg;

    logic             out_free;
    logic             res_valid;
    result_t          res;
    func_t            in_func;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;

    assign in_func  = func_t'(s_axis_tuser);
    assign out_free = !out_valid_reg || m_axis_tready;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.status;
    assign m_axis_tdata  = {out_data_reg.terms, out_data_reg.docs};

    tfct_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .USED_W  (USED_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_func     (in_func),
        .in_key      (s_axis_tdata[31:0]),
        .in_count    (s_axis_tdata[47:32]),
        .cap         (cap_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tfct_mem #(
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for term_frequency_count_table_unit: directed and random words.
module tb;
    import tfct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES  = ENTRIES_DEFAULT;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int POOL_SIZE      = 40;
    localparam int PHASE_WORDS    = 210;
    localparam int BURST_ADDS     = 4;

    localparam logic [CAP_W-1:0] CAP_MAX   = '1;
    localparam logic [KEY_W-1:0] BURST_KEY = 32'h0F0F_0F0F;

    // Mirror of the table: counters per key and the results they produce
    class count_table_mirror;
        logic [CTR_W-1:0] slot_docs[TABLE_ENTRIES];
        logic [CTR_W-1:0] slot_terms[TABLE_ENTRIES];
        int               slot_of[logic [KEY_W-1:0]];
        int unsigned      used;
        logic [CAP_W-1:0] capacity;
        result_t          pending_results[$];
        int               errors;

        function new();
            used     = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [CTR_W-1:0] sat_add(logic [CTR_W-1:0] a, logic [CTR_W-1:0] b);
            logic [CTR_W:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[CTR_W] ? '1 : sum[CTR_W-1:0];
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        // Predict the result of one accepted input word
        function void accept_request(func_t f, logic [KEY_W-1:0] key,
                                     logic [CNT_IN_W-1:0] cnt);
            result_t     r;
            int unsigned limit;
            int          slot;
            limit   = (capacity > TABLE_ENTRIES) ? TABLE_ENTRIES : capacity;
            r.status = STAT_UPDATED;
            r.docs   = '0;
            r.terms  = '0;
            if (f == FUNC_LOOKUP) begin
                if (used == 0)
                    r.status = STAT_EMPTY;
                else if (!slot_of.exists(key))
                    r.status = STAT_NOT_FOUND;
                else begin
                    slot    = slot_of[key];
                    r.docs  = slot_docs[slot];
                    r.terms = slot_terms[slot];
                end
            end
            else if (slot_of.exists(key)) begin
                slot             = slot_of[key];
                slot_docs[slot]  = sat_add(slot_docs[slot], 1);
                slot_terms[slot] = sat_add(slot_terms[slot], {16'd0, cnt});
                r.docs           = slot_docs[slot];
                r.terms          = slot_terms[slot];
            end
            else if (used < limit) begin
                slot_of[key]     = used;
                slot_docs[used]  = 1;
                slot_terms[used] = {16'd0, cnt};
                used++;
                r.status = STAT_INSERTED;
                r.docs   = 1;
                r.terms  = {16'd0, cnt};
            end
            else
                r.status = STAT_DROPPED;
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void compare_result(logic [2:0] status, logic [CTR_W-1:0] docs,
                                     logic [CTR_W-1:0] terms);
            result_t exp;
            if (pending_results.size() == 0) begin
                flag($sformatf("unexpected result: status %0d docs %0h terms %0h",
                               status, docs, terms));
                return;
            end
            exp = pending_results.pop_front();
            if (status !== exp.status || docs !== exp.docs || terms !== exp.terms)
                flag($sformatf("mismatch: status %0d/%0d docs %0h/%0h terms %0h/%0h (exp/got)",
                               exp.status, status, exp.docs, docs, exp.terms, terms));
        endfunction

        function void report_leftover();
            result_t exp;
            while (pending_results.size() != 0) begin
                exp = pending_results.pop_front();
                flag($sformatf("missing result: status %0d docs %0h terms %0h",
                               exp.status, exp.docs, exp.terms));
            end
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [47:0]         s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [63:0]         m_axis_tdata;
    logic [2:0]          m_axis_tuser;
    logic                cfg_wr_en     = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data   = '0;

    count_table_mirror   tracker;
    bit                  steady        = 1'b0;
    int                  quiet_cycles  = 0;
    logic [KEY_W-1:0]    key_pool[POOL_SIZE];
    logic [KEY_W-1:0]    corner_keys[4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                            32'h8000_0000, 32'h0000_0001};

    term_frequency_count_table_unit #(
        .ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #6 clk = ~clk;

    // Present one input word after a random gap, none in steady stretches, and wait for its handshake
    task automatic send_word(input func_t f, input logic [KEY_W-1:0] key,
                             input logic [CNT_IN_W-1:0] cnt);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {cnt, key};
        do @(posedge clk); while (!s_axis_tready);
        tracker.accept_request(f, key, cnt);
    endtask

    // Capacity write once every result is back and the block has settled
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_capacity(value);
    endtask

    // Result side: random stalls outside steady stretches, each accepted word checked
    initial
    begin
        int stall;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            tracker.compare_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main stimulus
    initial
    begin
        int               pick;
        func_t            f;
        logic [KEY_W-1:0] key;
        logic [CNT_IN_W-1:0] cnt;
        logic [CAP_W-1:0] cap;

        tracker = new();
        foreach (key_pool[i])
            key_pool[i] = $urandom();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // clearing sweep after reset holds tready low
        do @(posedge clk); while (!s_axis_tready);

        // capacity zero: new keys dropped, table stays empty
        write_capacity(11'd0);
        send_word(FUNC_LOOKUP, 32'h0000_0000, 16'h0000);
        send_word(FUNC_ADD,    32'hFFFF_FFFF, 16'hFFFF);
        send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);

        // capacity above table size clamps; zero count inserts and updates
        write_capacity(CAP_MAX);
        send_word(FUNC_ADD,    32'h0000_0000, 16'h0000);
        send_word(FUNC_ADD,    32'h0000_0000, 16'h0000);
        send_word(FUNC_ADD,    32'hFFFF_FFFF, 16'hFFFF);
        send_word(FUNC_ADD,    32'hFFFF_FFFF, 16'h0001);
        send_word(FUNC_LOOKUP, 32'h0000_0000, 16'hFFFF);
        send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
        send_word(FUNC_LOOKUP, 32'h1234_5678, 16'h0000);
        send_word(FUNC_ADD,    32'hAAAA_AAAA, 16'h5555);
        send_word(FUNC_ADD,    32'h5555_5555, 16'hAAAA);

        // capacity below used count: old keys live on, new ones dropped
        write_capacity(11'd2);
        send_word(FUNC_ADD,    32'h0000_0001, 16'h0003);
        send_word(FUNC_ADD,    32'hAAAA_AAAA, 16'h0007);
        send_word(FUNC_LOOKUP, 32'h0000_0001, 16'h0000);
        send_word(FUNC_LOOKUP, 32'h5555_5555, 16'h0000);
        send_word(FUNC_ADD,    32'h8000_0000, 16'hFFFF);

        // one free slot, then full again
        write_capacity(11'd5);
        send_word(FUNC_ADD,    32'h8000_0000, 16'hFFFF);
        send_word(FUNC_ADD,    32'h0000_0001, 16'h0001);
        send_word(FUNC_LOOKUP, 32'h0000_0001, 16'h0000);

        // back-to-back adds of the largest count to one key
        write_capacity(CAP_RESET);
        steady = 1'b1;
        send_word(FUNC_ADD, BURST_KEY, 16'hFFFF);
        for (int i = 0; i < BURST_ADDS; i++)
            send_word(FUNC_ADD, BURST_KEY, 16'hFFFF);
        send_word(FUNC_LOOKUP, BURST_KEY, 16'h0000);
        steady = 1'b0;

        // random phases under several capacities
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: cap = 11'd700;
                1: cap = (tracker.used > 4) ? CAP_W'(tracker.used - 4) : '0;
                2: cap = CAP_MAX;
                default: cap = 11'd1;
            endcase
            write_capacity(cap);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // short stretches without idling on either side
                steady = ((i % 70) < 12);
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (pick < 92)
                    key = $urandom();
                else
                    key = corner_keys[$urandom_range(0, 3)];
                f = ($urandom_range(0, 99) < 60) ? FUNC_ADD : FUNC_LOOKUP;
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    cnt = '0;
                else if (pick < 20)
                    cnt = '1;
                else if (pick < 60)
                    cnt = CNT_IN_W'($urandom_range(1, 20));
                else
                    cnt = CNT_IN_W'($urandom_range(0, 65535));
                send_word(f, key, cnt);
            end
        end
        steady = 1'b0;

        // drain and finish
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.report_leftover();
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tfct_pkg.sv
rtl/core/tfct_mem.sv
rtl/core/tfct_ctrl.sv
rtl/core/term_frequency_count_table_unit.sv
test/tb.sv
